### src/caf_pkg.sv
// Shared types for the CPU ALU with flags: operation codes, flag positions
// and the packed item structs for both directions. No dependencies.
package caf_pkg;

  typedef enum logic [4:0] {
    ALU_LD    = 5'd0,
    ALU_ADD   = 5'd1,
    ALU_ADC   = 5'd2,
    ALU_SUB   = 5'd3,
    ALU_SBC   = 5'd4,
    ALU_CP    = 5'd5,
    ALU_INC   = 5'd6,
    ALU_DEC   = 5'd7,
    ALU_AND   = 5'd8,
    ALU_OR    = 5'd9,
    ALU_XOR   = 5'd10,
    ALU_CPL   = 5'd11,
    ALU_CCF   = 5'd12,
    ALU_SCF   = 5'd13,
    ALU_RLC   = 5'd14,
    ALU_RL    = 5'd15,
    ALU_RRC   = 5'd16,
    ALU_RR    = 5'd17,
    ALU_ADD16 = 5'd18,
    ALU_INC16 = 5'd19,
    ALU_DEC16 = 5'd20,
    ALU_NOP   = 5'd21
  } alu_op_t;

  // Flag bit positions within the 4-bit flag word
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  typedef struct packed {
    alu_op_t     kind;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [3:0]  flags_in;
  } alu_in_t;

  typedef struct packed {
    logic [15:0] value;
    logic [3:0]  flags_out;
  } alu_out_t;

endpackage

### src/caf_alu.sv
// Combinational ALU datapath: value and Z N H C flags for one item.
// Depends on caf_pkg.
module caf_alu
  import caf_pkg::*;
(
  input  alu_in_t  item,
  output alu_out_t res
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic        use_c;
  logic [8:0]  sum9;
  logic [4:0]  hsum5;
  logic [8:0]  dif9;
  logic [4:0]  hdif5;
  logic [7:0]  v8;
  logic [16:0] sum17;
  logic [12:0] hsum13;
  logic [3:0]  fin;

  assign a   = item.operand_a[7:0];
  assign b   = item.operand_b[7:0];
  assign fin = item.flags_in;
  assign cin = fin[FLAG_C];

  // carry/borrow in only for adc and sbc
  assign use_c = ((item.kind == ALU_ADC) || (item.kind == ALU_SBC)) ? cin : 1'b0;

  assign sum9   = {1'b0, a} + {1'b0, b} + {8'd0, use_c};
  assign hsum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, use_c};
  // true 9-bit borrow: bit 8 set whenever a < b + use_c
  assign dif9   = {1'b0, a} - {1'b0, b} - {8'd0, use_c};
  assign hdif5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, use_c};
  assign sum17  = {1'b0, item.operand_a} + {1'b0, item.operand_b};
  assign hsum13 = {1'b0, item.operand_a[11:0]} + {1'b0, item.operand_b[11:0]};

  always_comb begin
    v8            = 8'd0;
    res.value     = item.operand_a;
    res.flags_out = fin;
    case (item.kind)
      ALU_LD: begin
        res.value = {8'd0, b};
      end
      ALU_ADD, ALU_ADC: begin
        v8 = sum9[7:0];
        res.value = {8'd0, v8};
        res.flags_out = {v8 == 8'd0, 1'b0, hsum5[4], sum9[8]};
      end
      ALU_SUB, ALU_SBC: begin
        v8 = dif9[7:0];
        res.value = {8'd0, v8};
        res.flags_out = {v8 == 8'd0, 1'b1, hdif5[4], dif9[8]};
      end
      ALU_CP: begin
        res.flags_out = {dif9[7:0] == 8'd0, 1'b1, hdif5[4], dif9[8]};
      end
      ALU_INC: begin
        v8 = a + 8'd1;
        res.value = {8'd0, v8};
        res.flags_out = {v8 == 8'd0, 1'b0, a[3:0] == 4'hF, cin};
      end
      ALU_DEC: begin
        v8 = a - 8'd1;
        res.value = {8'd0, v8};
        res.flags_out = {v8 == 8'd0, 1'b1, a[3:0] == 4'h0, cin};
      end
      ALU_AND: begin
        v8 = a & b;
        res.value = {8'd0, v8};
        res.flags_out = {v8 == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      ALU_OR: begin
        v8 = a | b;
        res.value = {8'd0, v8};
        res.flags_out = {v8 == 8'd0, 3'b000};
      end
      ALU_XOR: begin
        v8 = a ^ b;
        res.value = {8'd0, v8};
        res.flags_out = {v8 == 8'd0, 3'b000};
      end
      ALU_CPL: begin
        res.value = {8'd0, ~a};
        res.flags_out = {fin[FLAG_Z], 1'b1, 1'b1, cin};
      end
      ALU_CCF: begin
        res.flags_out = {fin[FLAG_Z], 1'b0, 1'b0, ~cin};
      end
      ALU_SCF: begin
        res.flags_out = {fin[FLAG_Z], 1'b0, 1'b0, 1'b1};
      end
      ALU_RLC: begin
        v8 = {a[6:0], a[7]};
        res.value = {8'd0, v8};
        res.flags_out = {v8 == 8'd0, 2'b00, a[7]};
      end
      ALU_RL: begin
        v8 = {a[6:0], cin};
        res.value = {8'd0, v8};
        res.flags_out = {v8 == 8'd0, 2'b00, a[7]};
      end
      ALU_RRC: begin
        v8 = {a[0], a[7:1]};
        res.value = {8'd0, v8};
        res.flags_out = {v8 == 8'd0, 2'b00, a[0]};
      end
      ALU_RR: begin
        v8 = {cin, a[7:1]};
        res.value = {8'd0, v8};
        res.flags_out = {v8 == 8'd0, 2'b00, a[0]};
      end
      ALU_ADD16: begin
        res.value = sum17[15:0];
        res.flags_out = {fin[FLAG_Z], 1'b0, hsum13[12], sum17[16]};
      end
      ALU_INC16: begin
        res.value = item.operand_a + 16'd1;
      end
      ALU_DEC16: begin
        res.value = item.operand_a - 16'd1;
      end
      default: begin
        // nop and unused codes: operand a and flags pass unchanged
        res.value     = item.operand_a;
        res.flags_out = fin;
      end
    endcase
  end

endmodule

### src/cpu_alu_with_flags.sv
// Top level of the CPU ALU with flags: input register, datapath, result register.
// Depends on caf_pkg and caf_alu.
//
// One item per clock, every clock. An item is taken on any rising edge with
// start high and busy low; busy is never raised, since nothing downstream
// can stall. Each item's result appears on result, with done high for exactly
// one cycle, after passing through the input register and then through the
// ALU into the result register. The receiver cannot hold results off, so it
// must capture result whenever done is high.
// Results leave in the order items arrived, one result per item.
module cpu_alu_with_flags
  import caf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  alu_in_t  item,
  output logic     done,
  output alu_out_t result
);

  // stage 1: captured item
  logic     in_valid;
  alu_in_t  in_item;

  // stage 2: ALU output, registered
  alu_out_t result_next;

  // never stalls: the pipeline advances unconditionally
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start & ~busy;
      done     <= in_valid;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    in_item <= item;
    result  <= result_next;
  end

  caf_alu u_alu (
    .item (in_item),
    .res  (result_next)
  );

endmodule

### src/caf_checker.sv
// Port-level checks for cpu_alu_with_flags, attached with a bind.
// Depends on caf_pkg.
module caf_checker
  import caf_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input alu_in_t  item,
  input logic     done,
  input alu_out_t result
);

  // every accepted item is followed by a done strobe
  a_item_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted item produced no result");

  // no done strobe without an earlier accepted item
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without accepted item");

  // flag-only operations return operand a untouched
  a_keep_a: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(item.kind, 2) == ALU_CP || $past(item.kind, 2) == ALU_CCF ||
              $past(item.kind, 2) == ALU_SCF || $past(item.kind, 2) == ALU_NOP))
    |-> result.value == $past(item.operand_a, 2))
    else $error("flag-only operation altered value");

  // 8-bit logic result has a clear upper byte, and and gives N=0 H=1 C=0
  a_and_flags: assert property (@(posedge clk) disable iff (rst)
    (done && $past(item.kind, 2) == ALU_AND)
    |-> (result.value[15:8] == 8'd0 && result.flags_out[2:0] == 3'b010))
    else $error("and result or flags wrong");

endmodule

bind cpu_alu_with_flags caf_checker u_caf_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);
